### sv/tfr_pkg.sv
package tfr_pkg;

  localparam int FrameLen = 9;
  localparam int CountW   = $clog2(FrameLen);
  localparam int NumRegs  = 8;
  localparam int CfgIdxW  = 4;
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  localparam logic [7:0]  START_BYTE  = 8'h7E;
  localparam logic [7:0]  ESCAPE_BYTE = 8'h7D;
  localparam logic [7:0]  ESCAPE_XOR  = 8'h20;
  localparam logic [7:0]  DATA_TYPE   = 8'h10;
  localparam logic [7:0]  SUM_GOOD    = 8'hFF;
  localparam logic [31:0] VOLT_SCALE  = 32'd10;
  localparam logic [31:0] CURR_SCALE  = 32'd100;

  // register indexes of the config port
  localparam logic [CfgIdxW-1:0] REG_SPEED_FIRST = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_SPEED_LAST  = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_ALT_FIRST   = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_ALT_LAST    = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_VOLT_FIRST  = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_VOLT_LAST   = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_CURR_FIRST  = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_CURR_LAST   = 4'd7;

  localparam logic [15:0] REG_RESET [NumRegs] = '{
    16'd272, 16'd287, 16'd256, 16'd271, 16'd528, 16'd543, 16'd512, 16'd527
  };

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_IN_FRAME = 2'd1,
    MODE_ESCAPE   = 2'd2
  } rx_mode_e;

  // one record per received byte, front to back
  typedef struct packed {
    logic        good;
    logic        bad;
    logic        data;
    logic [15:0] id;
    logic [31:0] value;
  } tfr_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tfr_qstat_t;

  function automatic logic [7:0] fold_add(logic [7:0] a, logic [7:0] b);
    logic [8:0] t;
    logic [8:0] u;
    t = {1'b0, a} + {1'b0, b};
    u = {1'b0, t[7:0]} + {8'd0, t[8]};
    return u[7:0] + {7'd0, u[8]};
  endfunction

endpackage

### sv/tfr_front.sv
module tfr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [7:0]        rx_byte_i,
  output tfr_pkg::tfr_rec_t rec_o
);
  import tfr_pkg::*;

  rx_mode_e          mode_q, mode_d;
  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        sum_q, sum_d;
  logic [7:0]        type_q;
  logic [15:0]       id_q;
  logic [31:0]       value_q;
  logic              store;
  logic [7:0]        sbyte;
  logic [7:0]        sum_new;
  logic              done;

  assign sum_new = fold_add(sum_q, sbyte);
  // checksum runs over bytes 1 and up
  assign sum_d   = (count_q == '0) ? 8'd0 : sum_new;

  always_comb begin
    mode_d  = mode_q;
    count_d = count_q;
    store   = 1'b0;
    sbyte   = rx_byte_i;
    done    = 1'b0;
    if (rx_byte_i == START_BYTE) begin
      mode_d  = MODE_IN_FRAME;
      count_d = '0;
    end else begin
      unique case (mode_q)
        MODE_ESCAPE: begin
          store  = 1'b1;
          sbyte  = rx_byte_i ^ ESCAPE_XOR;
          mode_d = MODE_IN_FRAME;
        end
        MODE_IN_FRAME: begin
          if (rx_byte_i == ESCAPE_BYTE) begin
            mode_d = MODE_ESCAPE;
          end else begin
            store = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (store) begin
      if (count_q == CountW'(FrameLen - 1)) begin
        done    = 1'b1;
        mode_d  = MODE_IDLE;
        count_d = '0;
      end else begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_comb begin
    rec_o.good  = done && (sum_new == SUM_GOOD);
    rec_o.bad   = done && (sum_new != SUM_GOOD);
    rec_o.data  = (type_q == DATA_TYPE);
    rec_o.id    = id_q;
    rec_o.value = value_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      count_q <= '0;
    end else if (push_i) begin
      mode_q  <= mode_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && store) begin
      sum_q <= sum_d;
      unique case (count_q)
        CountW'(1): type_q        <= sbyte;
        CountW'(2): id_q[7:0]     <= sbyte;
        CountW'(3): id_q[15:8]    <= sbyte;
        CountW'(4): value_q[7:0]  <= sbyte;
        CountW'(5): value_q[15:8] <= sbyte;
        CountW'(6): value_q[23:16] <= sbyte;
        CountW'(7): value_q[31:24] <= sbyte;
        default: ;
      endcase
    end
  end

endmodule

### sv/tfr_queue.sv
module tfr_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tfr_pkg::tfr_rec_t   rec_i,
  input  logic                pop_i,
  output tfr_pkg::tfr_rec_t   rec_o,
  output tfr_pkg::tfr_qstat_t stat_o
);
  import tfr_pkg::*;

  tfr_rec_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign rec_o        = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

endmodule

### sv/tfr_back.sv
module tfr_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [tfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  input  tfr_pkg::tfr_rec_t      rec_i,
  input  logic                   rec_valid_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [31:0]            speed_o,
  output logic [31:0]            altitude_o,
  output logic [31:0]            voltage_o,
  output logic [31:0]            current_o,
  output logic                   accepted_o,
  output logic                   bad_o
);
  import tfr_pkg::*;

  logic [15:0] regs_q [NumRegs];
  logic [31:0] speed_q, speed_d;
  logic [31:0] alt_q, alt_d;
  logic [31:0] base_q, base_d;
  logic [31:0] volt_q, volt_d;
  logic [31:0] curr_q, curr_d;
  logic        valid_q, acc_q, bad_q;
  logic        hit_speed, hit_alt, hit_volt, hit_curr;

  assign pop_o = rec_valid_i && (!valid_q || !out_stall_i);

  always_comb begin
    hit_speed = (rec_i.id >= regs_q[REG_SPEED_FIRST[2:0]])
             && (rec_i.id <= regs_q[REG_SPEED_LAST[2:0]]);
    hit_alt   = (rec_i.id >= regs_q[REG_ALT_FIRST[2:0]])
             && (rec_i.id <= regs_q[REG_ALT_LAST[2:0]]);
    hit_volt  = (rec_i.id >= regs_q[REG_VOLT_FIRST[2:0]])
             && (rec_i.id <= regs_q[REG_VOLT_LAST[2:0]]);
    hit_curr  = (rec_i.id >= regs_q[REG_CURR_FIRST[2:0]])
             && (rec_i.id <= regs_q[REG_CURR_LAST[2:0]]);

    speed_d = speed_q;
    alt_d   = alt_q;
    base_d  = base_q;
    volt_d  = volt_q;
    curr_d  = curr_q;
    if (rec_i.good && rec_i.data) begin
      priority if (hit_speed) begin
        speed_d = rec_i.value;
      end else if (hit_alt) begin
        // first nonzero reading becomes the zero point
        if (base_q == '0) begin
          base_d = 32'd0 - rec_i.value;
        end
        alt_d = rec_i.value + base_d;
      end else if (hit_volt) begin
        volt_d = 32'(rec_i.value * VOLT_SCALE);
      end else if (hit_curr) begin
        curr_d = 32'(rec_i.value * CURR_SCALE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= REG_RESET[i];
      end
      speed_q <= '0;
      alt_q   <= '0;
      base_q  <= '0;
      volt_q  <= '0;
      curr_q  <= '0;
      valid_q <= 1'b0;
      acc_q   <= 1'b0;
      bad_q   <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_index_i < CfgIdxW'(NumRegs))) begin
        regs_q[cfg_index_i[2:0]] <= cfg_data_i;
      end
      if (pop_o) begin
        speed_q <= speed_d;
        alt_q   <= alt_d;
        base_q  <= base_d;
        volt_q  <= volt_d;
        curr_q  <= curr_d;
        acc_q   <= rec_i.good;
        bad_q   <= rec_i.bad;
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign speed_o     = speed_q;
  assign altitude_o  = alt_q;
  assign voltage_o   = volt_q;
  assign current_o   = curr_q;
  assign accepted_o  = acc_q;
  assign bad_o       = bad_q;

endmodule

### sv/telemetry_frame_receiver_core.sv
// Byte-stuffed telemetry frame receiver. Every transfer on the input channel
// carries one raw link byte and yields exactly one result transfer holding the
// four telemetry values and the frame flags. The front end undoes the byte
// stuffing, keeps the running end-around-carry checksum and captures the frame
// fields in the cycle the byte arrives; a two-entry queue hands each byte's
// record to the back end, which matches the identifier ranges, scales the value
// and updates the registers as the record enters the output register. A byte
// is taken every cycle unless in_stall_o is high, and in_stall_o rises only
// when the queue is full behind a stalled output.
module telemetry_frame_receiver_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [3:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   vertical_speed_o,
  output logic signed [31:0]   relative_altitude_o,
  output logic signed [31:0]   battery_voltage_o,
  output logic [31:0]          battery_current_o,
  output logic                 frame_accepted_o,
  output logic                 checksum_bad_o
);
  import tfr_pkg::*;

  tfr_rec_t   front_rec;
  tfr_rec_t   q_rec;
  tfr_qstat_t q_stat;
  logic       push;
  logic       pop;
  logic [31:0] speed, alt, volt;

  assign in_stall_o = q_stat.full;
  assign push       = in_valid_i && !q_stat.full;

  tfr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .rx_byte_i (rx_byte_i),
    .rec_o     (front_rec)
  );

  tfr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (front_rec),
    .pop_i  (pop),
    .rec_o  (q_rec),
    .stat_o (q_stat)
  );

  tfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rec_i       (q_rec),
    .rec_valid_i (!q_stat.empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .speed_o     (speed),
    .altitude_o  (alt),
    .voltage_o   (volt),
    .current_o   (battery_current_o),
    .accepted_o  (frame_accepted_o),
    .bad_o       (checksum_bad_o)
  );

  assign vertical_speed_o    = $signed(speed);
  assign relative_altitude_o = $signed(alt);
  assign battery_voltage_o   = $signed(volt);

  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(frame_accepted_o && checksum_bad_o))
    else $error("good and bad frame flags both set");

  a_queue_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("back end took a record from an empty queue");

  a_pop_fills_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o)
    else $error("record taken but no result presented");

endmodule
